>>> hw/rtl/xkbt_pkg.sv
// Shared types and constants for the XT keyboard byte transmitter.
// Holds the transaction structs, the phase enum and the register map.
// No dependencies; every other file in this folder imports it.
package xkbt_pkg;

  // Width of the tick timer that counts phase lengths and the host wait.
  localparam int unsigned TIMER_BITS = 17;

  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned PULSE_W    = 12;
  localparam int unsigned SETUP_W    = 8;
  localparam int unsigned HOST_WAIT_W = 17;

  typedef logic [TIMER_BITS-1:0] timer_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_WAIT  = 4'd1,
    PH_SETUP = 4'd2,
    PH_FIRST = 4'd3,
    PH_HIGH  = 4'd4,
    PH_LOW   = 4'd5,
    PH_FINAL = 4'd6,
    PH_HOLD  = 4'd7,
    PH_GAP   = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    REG_FIRST_LOW  = 3'd0,
    REG_CLOCK_LOW  = 3'd1,
    REG_CLOCK_HIGH = 3'd2,
    REG_MAKE_HOLD  = 3'd3,
    REG_BREAK_HOLD = 3'd4,
    REG_GAP        = 3'd5,
    REG_SETUP      = 3'd6,
    REG_HOST_WAIT  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [PULSE_W-1:0]     first_low_ticks;
    logic [PULSE_W-1:0]     clock_low_ticks;
    logic [PULSE_W-1:0]     clock_high_ticks;
    logic [PULSE_W-1:0]     make_hold_ticks;
    logic [PULSE_W-1:0]     break_hold_ticks;
    logic [PULSE_W-1:0]     gap_ticks;
    logic [SETUP_W-1:0]     setup_ticks;
    logic [HOST_WAIT_W-1:0] host_wait_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    first_low_ticks:  12'd42,
    clock_low_ticks:  12'd26,
    clock_high_ticks: 12'd14,
    make_hold_ticks:  12'd640,
    break_hold_ticks: 12'd500,
    gap_ticks:        12'd200,
    setup_ticks:      8'd10,
    host_wait_ticks:  17'd100000
  };

  typedef struct packed {
    logic       send_request;
    logic [7:0] code_byte;
    logic       is_break;
    logic       host_clock;
  } in_item_t;

  typedef struct packed {
    logic clock_drive_low;
    logic data_drive_low;
    logic busy_res;
    logic done_res;
    logic timed_out;
  } out_item_t;

endpackage

>>> hw/rtl/xt_keyboard_byte_transmitter.sv
// Top level of the XT keyboard byte transmitter: input and result registers,
// handshake control and the configuration port. Depends on xkbt_pkg,
// xkbt_cfg and xkbt_step.

// Each input transaction is one microsecond tick carrying the sampled host
// clock line and an optional send request with a scan code and a make/break
// flag; each tick yields exactly one result transaction with the clock and
// data open-collector drives plus busy, done and timeout status. A request
// latches the byte and waits for the host to release the clock, giving up
// and pulsing timed_out after host_wait_ticks inhibited ticks. The waveform
// is a setup pause, a long first clock low pulse, eight data bits LSB first
// (each placed while clock is released, then clocked by a low pulse), data
// held low for the make or break hold time and an idle gap, after which
// done_res pulses. Timed phases whose register is zero are skipped within
// the same tick. The block takes one tick per clock cycle: a tick is held in
// an input register, and when it is processed the sequencer state and the
// result register update at the same edge, and the result register offers it.
// The rate is set by the single sequencer update per cycle, and the input
// is stalled only while the result register is full and stalled. Registers
// sit at byte address 4*i of the APB-style port; write them only while idle.
module xt_keyboard_byte_transmitter
  import xkbt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Tick input channel.
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  // Result channel.
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t      cfg;
  out_item_t result;

  logic      in_valid_q, in_valid_d;
  in_item_t  in_item_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;
  logic      fire;
  logic      in_take;

  // A tick is processed when one is held and the result register is free
  // or draining in this same cycle.
  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;
  assign in_take    = in_valid_i && !in_stall_o;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  xkbt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  xkbt_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item_i;
    end
    if (fire) begin
      out_item_q <= result;
    end
  end

endmodule

>>> hw/rtl/xkbt_cfg.sv
// Configuration register file for the XT keyboard byte transmitter.
// APB-style slave with always-ready access; depends on xkbt_pkg.
module xkbt_cfg
  import xkbt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_FIRST_LOW:  cfg_d.first_low_ticks  = pwdata[PULSE_W-1:0];
        REG_CLOCK_LOW:  cfg_d.clock_low_ticks  = pwdata[PULSE_W-1:0];
        REG_CLOCK_HIGH: cfg_d.clock_high_ticks = pwdata[PULSE_W-1:0];
        REG_MAKE_HOLD:  cfg_d.make_hold_ticks  = pwdata[PULSE_W-1:0];
        REG_BREAK_HOLD: cfg_d.break_hold_ticks = pwdata[PULSE_W-1:0];
        REG_GAP:        cfg_d.gap_ticks        = pwdata[PULSE_W-1:0];
        REG_SETUP:      cfg_d.setup_ticks      = pwdata[SETUP_W-1:0];
        REG_HOST_WAIT:  cfg_d.host_wait_ticks  = pwdata[HOST_WAIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FIRST_LOW:  prdata = CFG_DATA_W'(cfg_q.first_low_ticks);
      REG_CLOCK_LOW:  prdata = CFG_DATA_W'(cfg_q.clock_low_ticks);
      REG_CLOCK_HIGH: prdata = CFG_DATA_W'(cfg_q.clock_high_ticks);
      REG_MAKE_HOLD:  prdata = CFG_DATA_W'(cfg_q.make_hold_ticks);
      REG_BREAK_HOLD: prdata = CFG_DATA_W'(cfg_q.break_hold_ticks);
      REG_GAP:        prdata = CFG_DATA_W'(cfg_q.gap_ticks);
      REG_SETUP:      prdata = CFG_DATA_W'(cfg_q.setup_ticks);
      REG_HOST_WAIT:  prdata = CFG_DATA_W'(cfg_q.host_wait_ticks);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> hw/rtl/xkbt_step.sv
// Per-tick sequencer of the XT keyboard byte transmitter: phase state
// machine, bit shifter and tick timer. Depends on xkbt_pkg.
module xkbt_step
  import xkbt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      fire_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t result_o
);

  localparam timer_t TIMER_MAX = '1;
  localparam int unsigned CMP_W =
    (TIMER_BITS > HOST_WAIT_W) ? TIMER_BITS : HOST_WAIT_W;

  typedef struct packed {
    phase_e     phase;
    logic [2:0] bit_count;
    logic [7:0] shift_byte;
    timer_t     tick_timer;
    logic       break_flag;
  } state_t;

  typedef struct packed {
    state_t st;
    logic   done;
  } settle_t;

  state_t st_q, st_d;
  logic   done_d, timeout_d;

  // Walks forward from a candidate phase, skipping every timed phase whose
  // length is zero, and lands in the first phase that lasts, or in idle.
  // A run of zero-length bit phases is collapsed into one shift.
  function automatic settle_t settle(phase_e start, state_t s, cfg_t c);
    settle_t    r;
    phase_e     ph;
    logic       stop;
    logic [PULSE_W-1:0] hold_len;
    r        = '0;
    ph       = start;
    stop     = 1'b0;
    hold_len = s.break_flag ? c.break_hold_ticks : c.make_hold_ticks;
    r.st     = s;
    if (ph == PH_SETUP) begin
      if (c.setup_ticks != '0) begin
        stop = 1'b1;
        r.st.tick_timer = TIMER_BITS'(c.setup_ticks);
      end else begin
        ph = PH_FIRST;
      end
    end
    if (!stop && ph == PH_FIRST) begin
      if (c.first_low_ticks != '0) begin
        stop = 1'b1;
        r.st.tick_timer = TIMER_BITS'(c.first_low_ticks);
      end else begin
        r.st.bit_count = '0;
        ph = PH_HIGH;
      end
    end
    for (int pass = 0; pass < 2; pass++) begin
      if (!stop && ph == PH_HIGH) begin
        if (c.clock_high_ticks != '0) begin
          stop = 1'b1;
          r.st.tick_timer = TIMER_BITS'(c.clock_high_ticks);
        end else if (r.st.bit_count == 3'd7) begin
          ph = PH_FINAL;
        end else if (c.clock_low_ticks != '0) begin
          ph = PH_LOW;
        end else begin
          r.st.shift_byte = r.st.shift_byte >> (3'd7 - r.st.bit_count);
          r.st.bit_count  = 3'd7;
          ph = PH_FINAL;
        end
      end
      if (!stop && ph == PH_LOW) begin
        if (c.clock_low_ticks != '0) begin
          stop = 1'b1;
          r.st.tick_timer = TIMER_BITS'(c.clock_low_ticks);
        end else begin
          r.st.shift_byte = r.st.shift_byte >> 1;
          r.st.bit_count  = r.st.bit_count + 3'd1;
          ph = PH_HIGH;
        end
      end
    end
    if (!stop && ph == PH_FINAL) begin
      if (c.clock_low_ticks != '0) begin
        stop = 1'b1;
        r.st.tick_timer = TIMER_BITS'(c.clock_low_ticks);
      end else begin
        ph = PH_HOLD;
      end
    end
    if (!stop && ph == PH_HOLD) begin
      if (hold_len != '0) begin
        stop = 1'b1;
        r.st.tick_timer = TIMER_BITS'(hold_len);
      end else begin
        ph = PH_GAP;
      end
    end
    if (!stop && ph == PH_GAP) begin
      if (c.gap_ticks != '0) begin
        stop = 1'b1;
        r.st.tick_timer = TIMER_BITS'(c.gap_ticks);
      end else begin
        ph = PH_IDLE;
      end
    end
    if (!stop) begin
      ph = PH_IDLE;
      r.st.tick_timer = '0;
      r.done = 1'b1;
    end
    r.st.phase = ph;
    return r;
  endfunction

  // Next state.
  always_comb begin
    settle_t    sr;
    phase_e     next_ph;
    state_t     s;
    timer_t     t_inc;
    timer_t     limit;
    logic [CMP_W-1:0] hw_ext;
    st_d      = st_q;
    done_d    = 1'b0;
    timeout_d = 1'b0;
    sr        = '0;
    next_ph   = PH_IDLE;
    s         = st_q;
    t_inc     = (st_q.tick_timer != TIMER_MAX) ? st_q.tick_timer + 1'b1 : st_q.tick_timer;
    hw_ext    = CMP_W'(cfg_i.host_wait_ticks);
    limit     = (hw_ext > CMP_W'(TIMER_MAX)) ? TIMER_MAX
                                             : TIMER_BITS'(cfg_i.host_wait_ticks);
    case (st_q.phase)
      PH_IDLE: begin
        if (item_i.send_request) begin
          st_d.shift_byte = item_i.code_byte;
          st_d.break_flag = item_i.is_break;
          st_d.bit_count  = '0;
          st_d.tick_timer = '0;
          st_d.phase      = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (item_i.host_clock) begin
          sr     = settle(PH_SETUP, st_q, cfg_i);
          st_d   = sr.st;
          done_d = sr.done;
        end else if (t_inc >= limit) begin
          st_d.phase      = PH_IDLE;
          st_d.tick_timer = '0;
          timeout_d       = 1'b1;
        end else begin
          st_d.tick_timer = t_inc;
        end
      end
      PH_SETUP, PH_FIRST, PH_HIGH, PH_LOW, PH_FINAL, PH_HOLD, PH_GAP: begin
        if (st_q.tick_timer > timer_t'(1)) begin
          st_d.tick_timer = st_q.tick_timer - 1'b1;
        end else begin
          case (st_q.phase)
            PH_SETUP: next_ph = PH_FIRST;
            PH_FIRST: begin
              s.bit_count = '0;
              next_ph = PH_HIGH;
            end
            PH_HIGH:  next_ph = (st_q.bit_count == 3'd7) ? PH_FINAL : PH_LOW;
            PH_LOW: begin
              s.shift_byte = st_q.shift_byte >> 1;
              s.bit_count  = st_q.bit_count + 3'd1;
              next_ph = PH_HIGH;
            end
            PH_FINAL: next_ph = PH_HOLD;
            PH_HOLD:  next_ph = PH_GAP;
            default:  next_ph = PH_IDLE;
          endcase
          sr     = settle(next_ph, s, cfg_i);
          st_d   = sr.st;
          done_d = sr.done;
        end
      end
      default: begin
        st_d.phase      = PH_IDLE;
        st_d.tick_timer = '0;
      end
    endcase
  end

  // Line drives and status, taken from the state after this tick's update.
  always_comb begin
    logic bit_phase;
    bit_phase = (st_d.phase == PH_HIGH) || (st_d.phase == PH_LOW) ||
                (st_d.phase == PH_FINAL);
    result_o.clock_drive_low = (st_d.phase == PH_FIRST) || (st_d.phase == PH_LOW) ||
                               (st_d.phase == PH_FINAL);
    result_o.data_drive_low  = (bit_phase && !st_d.shift_byte[0]) ||
                               (st_d.phase == PH_HOLD);
    result_o.busy_res        = (st_d.phase != PH_IDLE);
    result_o.done_res        = done_d;
    result_o.timed_out       = timeout_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: PH_IDLE, bit_count: '0, shift_byte: '0,
                tick_timer: '0, break_flag: 1'b0};
    end else if (fire_i) begin
      st_q <= st_d;
    end
  end

endmodule
